/* rtl/apr_pkg.sv */
package apr_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int SAMPLE_BITS = 16;

   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int DLEN_W    = 10;
   localparam int GAIN_W    = 16;
   localparam int GAIN_FRAC = 15;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_DELAY_LENGTH = 1'b0;
   localparam logic [0:0] REG_GAIN         = 1'b1;

   localparam logic [DLEN_W-1:0] DELAY_LENGTH_RESET = DLEN_W'(1);
   localparam logic [GAIN_W-1:0] GAIN_RESET         = GAIN_W'(16384);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [GAIN_W-1:0]      gain_type;
   typedef logic [ADDR_W-1:0]             addr_type;

   typedef struct packed {
      logic load;
      logic negate;
   } mac_ctl_type;

endpackage

/* rtl/apr_if.sv */
interface apr_req_if;
   import apr_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface apr_rsp_if;
   import apr_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

/* rtl/apr_ram.sv */
module apr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/apr_mac.sv */
module apr_mac (
   input  logic                  clock,
   input  apr_pkg::mac_ctl_type  ctl,
   input  apr_pkg::gain_type     gain,
   input  apr_pkg::sample_type   operand,
   input  apr_pkg::sample_type   addend,
   output apr_pkg::sample_type   result
);
   import apr_pkg::*;

   localparam int PROD_W = GAIN_W + SAMPLE_BITS;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SHR_W  = SUM_W - GAIN_FRAC;
   localparam int ACC_W  = SHR_W + 1;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
   localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(64'sd1 <<< (GAIN_FRAC - 1));

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;
   logic signed [SUM_W-1:0]  term;
   logic signed [SUM_W-1:0]  rounded;
   logic signed [SHR_W-1:0]  scaled;
   logic signed [ACC_W-1:0]  acc;

   assign product_in = PROD_W'(gain) * PROD_W'(operand);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         product_ff <= product_in;
      end
   end

   // round to nearest, ties up: add half an lsb, then arithmetic shift
   always_comb begin
      term    = ctl.negate ? -SUM_W'(product_ff) : SUM_W'(product_ff);
      rounded = term + HALF;
      scaled  = SHR_W'(rounded >>> GAIN_FRAC);
      acc     = ACC_W'(scaled) + ACC_W'(addend);
      if (acc > SAT_HI) begin
         result = SAMPLE_BITS'(SAT_HI);
      end else if (acc < SAT_LO) begin
         result = SAMPLE_BITS'(SAT_LO);
      end else begin
         result = SAMPLE_BITS'(acc);
      end
   end
endmodule

/* rtl/allpass_reverberator_unit.sv */
// Schroeder allpass stage on a circular delay line of delay_length+1 samples
// (delay_length clamped to the store depth minus one). One sample beat in gives
// one sample beat out: s0 = x + g*sD and y = sD - g*s0 in Q1.15, rounded half up
// and saturated. A single multiplier with a rounding adder is shared by both
// products over four sequencer steps (MUL_SD, S0, MUL_S0, Y); rsp.valid rises
// when the last step completes, and req.ready returns in that same cycle, so a
// new req beat is taken only after the previous one has left the steps. A result
// that is still held in the output register stalls the last step until rsp.ready
// frees it. The delay memory read and write happen inside those steps. After
// reset the delay memory is zeroed by a clearing pass over all 1024 words during
// which req.ready is low; csr writes are taken at any time but must only be
// issued while idle.
module allpass_reverberator_unit (
   input  logic                             clock,
   input  logic                             reset,
   apr_req_if.sink                          req,
   apr_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [apr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [apr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [apr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import apr_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MUL_SD = 3'd2;
   localparam logic [2:0] ST_S0     = 3'd3;
   localparam logic [2:0] ST_MUL_S0 = 3'd4;
   localparam logic [2:0] ST_Y      = 3'd5;

   logic [2:0]        state_ff, state_in;
   addr_type          clr_addr_ff, clr_addr_in;
   addr_type          wpos_ff, wpos_in;
   logic [DLEN_W-1:0] dlen_ff, dlen_in;
   gain_type          gain_ff, gain_in;
   sample_type        x_ff, x_in;
   sample_type        sd_ff, sd_in;
   sample_type        s0_ff, s0_in;
   sample_type        out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   addr_type          d_eff;
   addr_type          rd_addr;
   logic              ram_wr_en;
   addr_type          ram_wr_addr;
   sample_type        ram_wr_data;
   sample_type        ram_rd_data;
   mac_ctl_type       mac_ctl;
   sample_type        mac_operand;
   sample_type        mac_addend;
   sample_type        mac_result;
   logic              csr_write;
   logic [0:0]        csr_index;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      dlen_in = dlen_ff;
      gain_in = gain_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DELAY_LENGTH: dlen_in = csr_pwdata[DLEN_W-1:0];
            REG_GAIN:         gain_in = csr_pwdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DELAY_LENGTH: csr_prdata = CSR_DATA_W'(dlen_ff);
         REG_GAIN:         csr_prdata = CSR_DATA_W'(gain_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // read tap sits one slot past the write position, wrapping at the line end
   always_comb begin
      if (32'(dlen_ff) > 32'(STORE_DEPTH - 1)) begin
         d_eff = ADDR_W'(STORE_DEPTH - 1);
      end else begin
         d_eff = ADDR_W'(dlen_ff);
      end
      rd_addr = (wpos_ff == '0) ? d_eff : wpos_ff - 1'b1;
   end

   assign ram_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_S0);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : wpos_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : mac_result;

   apr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign mac_ctl.load   = (state_ff == ST_MUL_SD) || (state_ff == ST_MUL_S0);
   assign mac_ctl.negate = (state_ff == ST_Y);
   assign mac_operand    = (state_ff == ST_MUL_SD) ? ram_rd_data : s0_ff;
   assign mac_addend     = (state_ff == ST_Y) ? sd_ff : x_ff;

   apr_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .gain    (gain_ff),
      .operand (mac_operand),
      .addend  (mac_addend),
      .result  (mac_result)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      wpos_in      = wpos_ff;
      x_in         = x_ff;
      sd_in        = sd_ff;
      s0_in        = s0_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               x_in     = req.sample_in;
               state_in = ST_MUL_SD;
            end
         end
         ST_MUL_SD: begin
            sd_in    = ram_rd_data;
            state_in = ST_S0;
         end
         ST_S0: begin
            s0_in    = mac_result;
            wpos_in  = rd_addr;
            state_in = ST_MUL_S0;
         end
         ST_MUL_S0: begin
            state_in = ST_Y;
         end
         ST_Y: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in       = mac_result;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wpos_ff      <= '0;
         dlen_ff      <= DELAY_LENGTH_RESET;
         gain_ff      <= GAIN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wpos_ff      <= wpos_in;
         dlen_ff      <= dlen_in;
         gain_ff      <= gain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      sd_ff  <= sd_in;
      s0_ff  <= s0_in;
      out_ff <= out_in;
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = out_valid_ff;
   assign rsp.sample_out = out_ff;
endmodule

/* rtl/apr_checker.sv */
module apr_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input apr_pkg::sample_type rsp_sample_out
);
   import apr_pkg::*;

   // a stalled result beat holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("rsp beat changed while stalled");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken again while busy");

   // clearing pass blocks input right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req ready during clearing pass");

   // with the output register free, an accepted beat must bring up the result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |-> ##5 rsp_valid)
      else $error("result beat late");
endmodule

bind allpass_reverberator_unit apr_checker u_apr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_sample_out (rsp.sample_out)
);

/* bench/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import apr_pkg::*;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   apr_req_if req_if ();
   apr_rsp_if rsp_if ();

   allpass_reverberator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5ns clock = ~clock;

   // filter state mirrored on the bench side
   sample_type        delay_line [STORE_DEPTH];
   int                write_pos;
   logic [DLEN_W-1:0] line_length;
   gain_type          coeff;

   sample_type pending_samples[$];
   sample_type expected_out[$];
   int         failures = 0;
   bit         req_taken = 1'b0;
   bit         steady = 1'b0;

   function automatic longint round_q15(input longint v);
      return (v + 64'sd16384) >>> GAIN_FRAC;
   endfunction

   function automatic sample_type saturate_sample(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return sample_type'(hi);
      if (v < lo) return sample_type'(lo);
      return sample_type'(v);
   endfunction

   // one allpass step: returns y and advances the delay line
   function automatic sample_type allpass_predict(input sample_type x);
      int         d;
      int         p;
      int         rd;
      longint     sd;
      sample_type s0;
      sample_type y;
      d = int'(line_length);
      if (d > STORE_DEPTH - 1) d = STORE_DEPTH - 1;
      p = write_pos % STORE_DEPTH;
      // position may sit past the line after the delay shrinks
      rd = p + d;
      if (rd >= d + 1) rd -= d + 1;
      rd = rd % STORE_DEPTH;
      sd = longint'(delay_line[rd]);
      s0 = saturate_sample(longint'(x) + round_q15(longint'(coeff) * sd));
      y = saturate_sample(round_q15(-longint'(coeff) * longint'(s0)) + sd);
      delay_line[p] = s0;
      write_pos = (p == 0) ? d : p - 1;
      return y;
   endfunction

   // sample beat driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_samples.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
            req_if.valid <= 1'b1;
            req_if.sample_in <= pending_samples.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !reset && (steady || $urandom_range(0, 99) >= 19);
   end

   always @(posedge clock) begin
      req_taken = !reset && req_if.valid && req_if.ready;
      if (req_taken) expected_out.push_back(allpass_predict(req_if.sample_in));
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_out.size() == 0) begin
            $error("sample_out beat with nothing expected: actual %0d", rsp_if.sample_out);
            failures++;
         end else begin
            sample_type want;
            want = expected_out.pop_front();
            if (rsp_if.sample_out !== want) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      want, rsp_if.sample_out);
               failures++;
            end
         end
      end
   end

   task automatic csr_write(input logic [0:0] index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_DELAY_LENGTH) line_length = data[DLEN_W-1:0];
      else coeff = gain_type'(data[GAIN_W-1:0]);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // wait until every sample has come back
   // checked at the rising edge so a beat the driver just launched is seen
   task automatic settle();
      while (pending_samples.size() != 0 || req_if.valid || expected_out.size() != 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic load_setting(input logic [DLEN_W-1:0] dlen, input gain_type g);
      settle();
      csr_write(REG_DELAY_LENGTH, CSR_DATA_W'(dlen));
      csr_write(REG_GAIN, CSR_DATA_W'($unsigned(g)));
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 7))
         0: return sample_type'(16'sh7fff);
         1: return sample_type'(16'sh8000);
         default: return sample_type'($urandom);
      endcase
   endfunction

   initial begin
      sample_type        full_swing [6];
      sample_type        zero_delay [6];
      sample_type        long_line [6];
      sample_type        shrunk_line [6];
      int                random_total;
      int                phase;
      int                count;
      logic [DLEN_W-1:0] dlen;
      gain_type          g;

      full_swing  = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000, 16'shffff};
      zero_delay  = '{16'sh7fff, 16'sh0001, 16'sh8000, 16'sh0000, 16'shffff, 16'sh7fff};
      long_line   = '{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh0000};
      shrunk_line = '{16'sh8000, 16'sh7fff, 16'sh1234, 16'shedcb, 16'sh8000, 16'sh7fff};

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      foreach (delay_line[i]) delay_line[i] = '0;
      write_pos = 0;
      line_length = DELAY_LENGTH_RESET;
      coeff = gain_type'(GAIN_RESET);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting, saturating swings
      foreach (full_swing[i]) pending_samples.push_back(full_swing[i]);
      // one-word line with gain of exactly -1.0
      load_setting(DLEN_W'(0), gain_type'(16'sh8000));
      foreach (zero_delay[i]) pending_samples.push_back(zero_delay[i]);
      // longest line, largest positive gain
      load_setting(DLEN_W'(1023), gain_type'(16'sh7fff));
      foreach (long_line[i]) pending_samples.push_back(long_line[i]);
      // shrink the line while the position sits far past its end
      load_setting(DLEN_W'(2), gain_type'(-16'sd32767));
      foreach (shrunk_line[i]) pending_samples.push_back(shrunk_line[i]);

      random_total = 0;
      phase = 0;
      while (random_total < 790) begin
         if ($urandom_range(0, 4) == 0) dlen = DLEN_W'($urandom_range(0, 1023));
         else dlen = DLEN_W'($urandom_range(0, 24));
         case ($urandom_range(0, 9))
            0: g = gain_type'(16'sh8000);
            1: g = gain_type'(16'sh7fff);
            2: g = gain_type'(-16'sd32767);
            default: g = gain_type'($urandom);
         endcase
         load_setting(dlen, g);
         steady = (phase == 2);
         count = $urandom_range(30, 110);
         repeat (count) pending_samples.push_back(random_sample());
         random_total += count;
         phase++;
      end

      settle();
      steady = 1'b0;
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("tb_top failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/apr_pkg.sv
rtl/apr_if.sv
rtl/apr_ram.sv
rtl/apr_mac.sv
rtl/allpass_reverberator_unit.sv
rtl/apr_checker.sv
bench/tb_top.sv
